// ===== rtl/core/dlcar_pkg.sv =====
// shared types and constants for the dual load cell converter reader
package dlcar_pkg;

  localparam int SLOPE_W     = 32;
  localparam int OFFSET_W    = 56;
  localparam int CFG_DATA_W  = 56;
  localparam int CFG_INDEX_W = 8;
  localparam int WEIGHT_W    = 40;
  localparam int TOTAL_W     = 41;
  localparam int SUM_W       = 66;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_SLOPE_A  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_A = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_SLOPE_B  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_B = CFG_INDEX_W'(3);

  localparam logic signed [SLOPE_W-1:0]  SLOPE_RESET  = SLOPE_W'(65536);
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = '0;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  // per-item control passed from the front end to the scaling pipeline
  typedef struct packed {
    logic pulse;
    logic done;
  } ctl_t;

endpackage

// ===== rtl/core/dlcar_if.sv =====
// channel interfaces for the dual load cell converter reader
interface dlcar_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic dout_a;
  logic dout_b;

  modport source (output valid, start_req, dout_a, dout_b, input ready);
  modport sink (input valid, start_req, dout_a, dout_b, output ready);
endinterface

interface dlcar_out_if #(
  parameter int DATA_BITS = 24
);
  logic                                    valid;
  logic                                    ready;
  logic                                    clock_pulse;
  logic                                    done_res;
  logic [DATA_BITS-1:0]                    raw_a;
  logic [DATA_BITS-1:0]                    raw_b;
  logic signed [dlcar_pkg::WEIGHT_W-1:0]   weight_a;
  logic signed [dlcar_pkg::WEIGHT_W-1:0]   weight_b;
  logic signed [dlcar_pkg::TOTAL_W-1:0]    weight_total;

  modport source (output valid, clock_pulse, done_res, raw_a, raw_b, weight_a, weight_b,
                  weight_total, input ready);
  modport sink (input valid, clock_pulse, done_res, raw_a, raw_b, weight_a, weight_b,
                weight_total, output ready);
endinterface

// ===== rtl/core/dlcar_front.sv =====
// front end: frame sequencing and serial bit capture for both channels
module dlcar_front #(
  parameter int DATA_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  dlcar_in_if.sink              in_ch,
  input  logic                  q_full,
  output logic                  push,
  output dlcar_pkg::ctl_t       cmd,
  output logic [DATA_BITS-1:0]  word_a,
  output logic [DATA_BITS-1:0]  word_b
);

  localparam int CNT_W = $clog2(DATA_BITS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     pulse_count;
  logic [DATA_BITS-1:0] shift_a;
  logic [DATA_BITS-1:0] shift_b;
  logic                 last_pulse;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;
  assign last_pulse  = busy && (pulse_count == CNT_W'(DATA_BITS));

  always_comb begin
    cmd.pulse = busy;
    cmd.done  = last_pulse;
    // two's complement to offset binary
    word_a    = {~shift_a[DATA_BITS-1], shift_a[DATA_BITS-2:0]};
    word_b    = {~shift_b[DATA_BITS-1], shift_b[DATA_BITS-2:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pulse_count <= '0;
      shift_a     <= '0;
      shift_b     <= '0;
    end else if (push) begin
      if (!busy) begin
        if (in_ch.start_req) begin
          busy        <= 1'b1;
          pulse_count <= '0;
          shift_a     <= '0;
          shift_b     <= '0;
        end
      end else if (last_pulse) begin
        busy        <= 1'b0;
        pulse_count <= '0;
      end else begin
        pulse_count <= pulse_count + CNT_W'(1);
        shift_a     <= {shift_a[DATA_BITS-2:0], in_ch.dout_a};
        shift_b     <= {shift_b[DATA_BITS-2:0], in_ch.dout_b};
      end
    end
  end

  // frame ends only on the pulse after the last data bit
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> $past(push && pulse_count == CNT_W'(DATA_BITS)))
    else $error("frame ended without final pulse");

  a_pulse_busy: assert property (@(posedge clk) disable iff (rst)
    push |-> (cmd.pulse == busy) && (!cmd.done || busy))
    else $error("pulse flag out of step with frame state");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !push |=> $stable(pulse_count) && $stable(busy))
    else $error("frame state moved without a transaction");

endmodule

// ===== rtl/core/dlcar_queue.sv =====
// short queue between the front end and the scaling pipeline
module dlcar_queue #(
  parameter int WIDTH = 50
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = $clog2(dlcar_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] mem [dlcar_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_W'(dlcar_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("write into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(push) && !$past(do_pop) |-> count == $past(count) + CNT_W'(1))
    else $error("queue fill level lost a write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || full) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with fill level");

endmodule

// ===== rtl/core/dlcar_back.sv =====
// back end: calibration registers, scaling pipeline and result register
module dlcar_back #(
  parameter int DATA_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dlcar_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dlcar_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  head_valid,
  input  dlcar_pkg::ctl_t                       head_ctl,
  input  logic [DATA_BITS-1:0]                  head_raw_a,
  input  logic [DATA_BITS-1:0]                  head_raw_b,
  output logic                                  pop,
  dlcar_out_if.source                           out_ch
);

  localparam int PROD_W = DATA_BITS + dlcar_pkg::SLOPE_W;
  localparam int SUM_W  = dlcar_pkg::SUM_W;
  localparam int W_W    = dlcar_pkg::WEIGHT_W;
  localparam int T_W    = dlcar_pkg::TOTAL_W;

  logic signed [dlcar_pkg::SLOPE_W-1:0]  slope_a, slope_b;
  logic signed [dlcar_pkg::OFFSET_W-1:0] offset_a, offset_b;

  logic                  adv;
  logic signed [PROD_W-1:0] prod_a, prod_b;

  logic                     s1_valid;
  dlcar_pkg::ctl_t          s1_ctl;
  logic [DATA_BITS-1:0]     s1_raw_a, s1_raw_b;
  logic signed [PROD_W-1:0] s1_prod_a, s1_prod_b;

  logic                     s2_valid;
  dlcar_pkg::ctl_t          s2_ctl;
  logic [DATA_BITS-1:0]     s2_raw_a, s2_raw_b;
  logic signed [SUM_W-1:0]  s2_sum_a, s2_sum_b;

  logic                     s3_valid;
  dlcar_pkg::ctl_t          s3_ctl;
  logic [DATA_BITS-1:0]     s3_raw_a, s3_raw_b;
  logic signed [W_W-1:0]    s3_w_a, s3_w_b;

  logic                     out_valid;
  dlcar_pkg::ctl_t          out_ctl;
  logic [DATA_BITS-1:0]     out_raw_a, out_raw_b;
  logic signed [W_W-1:0]    out_w_a, out_w_b;
  logic signed [T_W-1:0]    out_total;

  // floor shift out the fraction, then clamp to the weight range
  function automatic logic signed [W_W-1:0] sat_weight(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] sh;
    logic [SUM_W-W_W:0]      top;
    sh  = v >>> FRAC_BITS;
    top = sh[SUM_W-1:W_W-1];
    if (top == '0 || top == '1) begin
      return sh[W_W-1:0];
    end else if (sh[SUM_W-1]) begin
      return dlcar_pkg::WEIGHT_MIN;
    end else begin
      return dlcar_pkg::WEIGHT_MAX;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_a  <= dlcar_pkg::SLOPE_RESET;
      offset_a <= dlcar_pkg::OFFSET_RESET;
      slope_b  <= dlcar_pkg::SLOPE_RESET;
      offset_b <= dlcar_pkg::OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlcar_pkg::REG_SLOPE_A:  slope_a  <= cfg_data[dlcar_pkg::SLOPE_W-1:0];
        dlcar_pkg::REG_OFFSET_A: offset_a <= cfg_data[dlcar_pkg::OFFSET_W-1:0];
        dlcar_pkg::REG_SLOPE_B:  slope_b  <= cfg_data[dlcar_pkg::SLOPE_W-1:0];
        dlcar_pkg::REG_OFFSET_B: offset_b <= cfg_data[dlcar_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves together whenever the result register can take a word
  assign adv = !out_valid || out_ch.ready;
  assign pop = adv && head_valid;

  // raw word is unsigned, so widen it with a zero before the signed multiply
  assign prod_a = $signed(PROD_W'({1'b0, head_raw_a})) * PROD_W'(slope_a);
  assign prod_b = $signed(PROD_W'({1'b0, head_raw_b})) * PROD_W'(slope_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= head_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl    <= head_ctl;
      s1_raw_a  <= head_raw_a;
      s1_raw_b  <= head_raw_b;
      s1_prod_a <= prod_a;
      s1_prod_b <= prod_b;

      s2_ctl   <= s1_ctl;
      s2_raw_a <= s1_raw_a;
      s2_raw_b <= s1_raw_b;
      s2_sum_a <= SUM_W'(s1_prod_a) + SUM_W'(offset_a);
      s2_sum_b <= SUM_W'(s1_prod_b) + SUM_W'(offset_b);

      s3_ctl   <= s2_ctl;
      s3_raw_a <= s2_raw_a;
      s3_raw_b <= s2_raw_b;
      s3_w_a   <= sat_weight(s2_sum_a);
      s3_w_b   <= sat_weight(s2_sum_b);

      if (s3_valid) begin
        out_ctl <= s3_ctl;
      end
    end
  end

  // result register doubles as the last-frame store
  always_ff @(posedge clk) begin
    if (rst) begin
      out_raw_a <= '0;
      out_raw_b <= '0;
      out_w_a   <= '0;
      out_w_b   <= '0;
      out_total <= '0;
    end else if (adv && s3_valid && s3_ctl.done) begin
      out_raw_a <= s3_raw_a;
      out_raw_b <= s3_raw_b;
      out_w_a   <= s3_w_a;
      out_w_b   <= s3_w_b;
      out_total <= T_W'(s3_w_a) + T_W'(s3_w_b);
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.clock_pulse  = out_ctl.pulse;
  assign out_ch.done_res     = out_ctl.done;
  assign out_ch.raw_a        = out_raw_a;
  assign out_ch.raw_b        = out_raw_b;
  assign out_ch.weight_a     = out_w_a;
  assign out_ch.weight_b     = out_w_b;
  assign out_ch.weight_total = out_total;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s1_valid) && $stable(s2_valid) && $stable(s3_valid))
    else $error("pipeline moved while result stalled");

  a_done_load: assert property (@(posedge clk) disable iff (rst)
    adv && s3_valid && s3_ctl.done |=> out_w_a == $past(s3_w_a) && out_w_b == $past(s3_w_b))
    else $error("frame weights not loaded into result");

  a_total_sum: assert property (@(posedge clk) disable iff (rst)
    out_total == T_W'(out_w_a) + T_W'(out_w_b))
    else $error("total weight differs from channel sum");

endmodule

// ===== rtl/core/dual_load_cell_adc_reader.sv =====
// top level of the dual load cell converter reader
// usage:
//   in_ch carries one transaction per step of the serial sequence: a start
//   request from the sampling timer while idle, then one transaction per clock
//   pulse to both converters, with the data line levels seen after that pulse.
//   out_ch returns exactly one transaction per input transaction, in order,
//   flagging the pulse, the frame end and the latest offset-binary words,
//   weights in milligrams and their sum.
//   the user writes calibration slope and offset via cfg_we/cfg_index/cfg_data
//   between frames only (not enforced); index values above three are dropped.
// timing:
//   a taken input passes the queue, the per-channel multiply, the offset add
//   and the shift/clamp, each one pipeline stage, then the result register;
//   one input is taken every cycle while the queue is not full.
// reset:
//   slopes return to unity gain, offsets to zero, stored words and weights to
//   zero, and the reader is idle awaiting a start.
// stall:
//   while out_ch is not ready the pipeline holds; the four-entry queue keeps
//   taking input until full, then in_ch.ready drops.
module dual_load_cell_adc_reader #(
  parameter int DATA_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  dlcar_in_if.sink                           in_ch,
  dlcar_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [dlcar_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dlcar_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CTL_W = $bits(dlcar_pkg::ctl_t);
  localparam int Q_W   = CTL_W + 2 * DATA_BITS;

  logic                 q_full;
  logic                 push;
  dlcar_pkg::ctl_t      cmd;
  logic [DATA_BITS-1:0] word_a, word_b;
  logic                 pop;
  logic                 head_valid;
  logic [Q_W-1:0]       head_data;
  dlcar_pkg::ctl_t      head_ctl;
  logic [DATA_BITS-1:0] head_raw_a, head_raw_b;

  dlcar_front #(
    .DATA_BITS (DATA_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (cmd),
    .word_a (word_a),
    .word_b (word_b)
  );

  dlcar_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({cmd, word_a, word_b}),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_ctl   = head_data[Q_W-1 -: CTL_W];
  assign head_raw_a = head_data[2*DATA_BITS-1 -: DATA_BITS];
  assign head_raw_b = head_data[DATA_BITS-1:0];

  dlcar_back #(
    .DATA_BITS (DATA_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_raw_a (head_raw_a),
    .head_raw_b (head_raw_b),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
